// ----- design/kernel_regression_smoother_unit_defines.svh -----
// Assertion macros for the kernel regression smoother unit.
// Used by the port checker; needs clk and rst in the scope of each use.
`ifndef KERNEL_REGRESSION_SMOOTHER_UNIT_DEFINES_SVH
`define KERNEL_REGRESSION_SMOOTHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KRS_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kernel smoother check failed");

// Next-cycle implication, disabled during reset.
`define KRS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kernel smoother check failed");

// Next-cycle implication that also holds across reset.
`define KRS_CHECK_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kernel smoother check failed");

`endif

// ----- design/krs_pkg.sv -----
// Shared types, codes and constants of the kernel regression smoother.
// No dependencies; imported by every module of the block.
`default_nettype none
package krs_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] KSEL_BOX    = 2'd1;
  localparam logic [1:0] KSEL_NORMAL = 2'd2;

  localparam logic REG_KERNEL_SELECT = 1'b0;
  localparam logic REG_BANDWIDTH     = 1'b1;

  localparam logic [1:0]  KSEL_RESET      = 2'd1;
  localparam logic [30:0] BANDWIDTH_RESET = 31'd65536;
  localparam logic [16:0] WEIGHT_ONE      = 17'd65536;
  localparam logic [31:0] NORMAL_SCALE_Q32 = 32'd1591932205;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] point_x;
    logic signed [31:0] sample_y;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic               estimate_valid;
  } rsp_word_t;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
    logic long_div;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  // exp(-k) in Q0.32 for k = 0..7.
  function automatic logic [63:0] neg_exp_whole(input logic [63:0] k);
    logic [63:0] r;
    case (k[2:0])
      3'd0: r = 64'd4294967295;
      3'd1: r = 64'd1580030169;
      3'd2: r = 64'd581260615;
      3'd3: r = 64'd213833831;
      3'd4: r = 64'd78665071;
      3'd5: r = 64'd28939262;
      3'd6: r = 64'd10646158;
      default: r = 64'd3916503;
    endcase
    return r;
  endfunction

  // Weight table entry from its exponent t (Q32); used at elaboration only.
  function automatic logic [16:0] weight_entry(input logic [63:0] t, input logic first);
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] term;
    logic signed [64:0] sum;
    logic [63:0] e;
    k = t >> 32;
    f = t & 64'hFFFF_FFFF;
    term = 64'h1_0000_0000;
    sum = 65'sh1_0000_0000;
    e = 64'd0;
    if (k <= 64'd7) begin
      for (int n = 1; n <= 13; n++) begin
        term = ((term * f) >> 32) / 64'(n);
        if ((n & 1) != 0) sum = sum - $signed({1'b0, term});
        else sum = sum + $signed({1'b0, term});
      end
      if (sum < 0) sum = 65'sd0;
      if (sum > 65'sh0_FFFF_FFFF) sum = 65'sh0_FFFF_FFFF;
      e = (neg_exp_whole(k) * sum[63:0]) >> 32;
    end
    if (first) return WEIGHT_ONE;
    return 17'((e + 64'd32768) >> 16);
  endfunction

endpackage
`default_nettype wire

// ----- design/krs_weight_rom.sv -----
// Normal-kernel weight table with a registered read port.
// Depends on krs_pkg for the entry function.
`default_nettype none
module krs_weight_rom #(
  parameter int WEIGHT_TABLE_SIZE = 256
) (
  input  wire logic                                 clk,
  input  wire logic [$clog2(WEIGHT_TABLE_SIZE)-1:0] addr,
  output logic [16:0]                               weight
);
  import krs_pkg::*;

  logic [16:0] rom_data [WEIGHT_TABLE_SIZE];

  for (genvar g = 0; g < WEIGHT_TABLE_SIZE; g++) begin : g_entry
    localparam logic [63:0] T =
      (64'(8 * g * g) << 32) / 64'(WEIGHT_TABLE_SIZE * WEIGHT_TABLE_SIZE);
    assign rom_data[g] = weight_entry(T, g == 0);
  end

  always_ff @(posedge clk) begin
    weight <= rom_data[addr];
  end

endmodule
`default_nettype wire

// ----- design/krs_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on krs_pkg for the request and response structs.
`default_nettype none
module krs_divider #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int SHORT_BITS = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire krs_pkg::div_req_t        req,
  input  wire logic [NW-1:0]            numer,
  input  wire logic [DW-1:0]            denom,
  output krs_pkg::div_rsp_t             rsp,
  output logic [31:0]                   quot
);
  import krs_pkg::*;

  localparam int RW = (NW > DW + 32) ? NW : DW + 32;

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [5:0]    cnt;
  logic          busy;
  logic          done;
  logic          fits;

  assign fits = rem >= dsh;
  assign rsp.busy = busy;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= RW'(numer);
        quot <= '0;
        if (req.long_div) begin
          dsh <= RW'(denom) << 31;
          cnt <= 6'd32;
        end else begin
          dsh <= RW'(denom) << (SHORT_BITS - 1);
          cnt <= 6'(SHORT_BITS);
        end
      end else if (busy) begin
        if (fits) rem <= rem - dsh;
        quot <= {quot[30:0], fits};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/kernel_regression_smoother_unit.sv -----
// Top level of the kernel regression (Nadaraya-Watson) smoother.
// Depends on krs_pkg, krs_divider and krs_weight_rom.
//
// Usage. Request words arrive on req_valid/req_ready with a mode, an
// abscissa and an ordinate. A clear or a load word returns nothing;
// a load past capacity is dropped. A query word returns exactly one
// response word on rsp_valid/rsp_ready holding the weighted average
// of the stored points inside the kernel window around point_x,
// rounded to nearest and saturated, with estimate_valid low when no
// weight was summed.
// Work on a query: the setup states S_SCALE and S_BOUND, then per
// scanned point S_FETCH and S_CHECK, followed for a summed point by
// S_MUL and S_ACC; a normal-kernel point first passes S_IDX_WAIT,
// where the index division runs on the shared divider, and S_ROM.
// Then come S_ROUND, S_RANGE and the final division on that divider.
// One query is in work at a time.
// The response sits in an output register, so a stalled receiver only
// holds the block once a second query result is ready to be stored.
// Reset is synchronous: it empties the store, moves the window start to
// zero and restores kernel_select to box and bandwidth to 1.0. The
// sample memory itself is not cleared; entries are read only after load.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at
// once. Make them only while the block is idle; nothing here enforces it.
`default_nettype none
module kernel_regression_smoother_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int WEIGHT_TABLE_SIZE = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire krs_pkg::req_word_t req_word,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output krs_pkg::rsp_word_t      rsp_word,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import krs_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int QW = $clog2(WEIGHT_TABLE_SIZE + 1);
  localparam int IW = $clog2(WEIGHT_TABLE_SIZE);
  // Worst-case sums: 17-bit weight times 32-bit ordinate over the store.
  localparam int NUM_W = 49 + CW;
  localparam int DEN_W = 17 + CW;
  localparam int FIN_W = NUM_W + 1;
  localparam int IDX_NW = 33 + QW;
  localparam int DIV_NW = (FIN_W > IDX_NW) ? FIN_W : IDX_NW;
  localparam int DIV_DW = (DEN_W > 33) ? DEN_W : 33;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_BOUND, S_FETCH, S_CHECK, S_IDX_WAIT, S_ROM,
    S_MUL, S_ACC, S_ROUND, S_RANGE, S_Q_WAIT, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]  kernel_select;
  logic [30:0] bandwidth;

  // Sample store.
  logic [31:0] abscissa_store [MAX_SAMPLES];
  logic [31:0] ordinate_store [MAX_SAMPLES];
  logic [31:0] rd_x;
  logic [31:0] rd_y;
  logic [CW-1:0] stored_count;
  logic [AW-1:0] window_start;

  // Query working registers.
  logic signed [31:0] qx;
  logic [32:0]        s18;
  logic signed [34:0] lo;
  logic signed [34:0] hi;
  logic [CW-1:0]      scan;
  logic [IW-1:0]      rom_addr;
  logic [16:0]        wbox;
  logic [16:0]        w;
  logic signed [49:0] prod;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]   den;
  logic               neg;
  logic [FIN_W-1:0]   nfin;
  rsp_word_t          res;

  // Combinational helpers.
  logic [62:0]        scale_prod;
  logic [32:0]        cutoff;
  logic signed [34:0] xi;
  logic signed [34:0] diff;
  logic [32:0]        abs_dx;
  logic [16:0]        rom_w;
  logic [16:0]        wsel;
  logic [NUM_W-1:0]   mag;
  logic [QW-1:0]      qshort;
  logic [IW-1:0]      idx_clamped;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DIV_NW-1:0] div_numer;
  logic [DIV_DW-1:0] div_denom;
  logic [31:0]       div_quot;

  assign req_ready = (state == S_IDLE);

  assign scale_prod = 63'(bandwidth) * 63'(NORMAL_SCALE_Q32);

  always_comb begin
    case (kernel_select)
      KSEL_BOX:    cutoff = s18 >> 2;
      KSEL_NORMAL: cutoff = s18;
      default:     cutoff = '0;
    endcase
  end

  assign xi   = 35'($signed(rd_x));
  assign diff = xi - 35'(qx);
  assign abs_dx = diff[34] ? 33'(-diff) : 33'(diff);
  assign wsel = (kernel_select == KSEL_NORMAL) ? rom_w : wbox;
  assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign qshort = div_quot[QW-1:0];
  assign idx_clamped = (qshort >= QW'(WEIGHT_TABLE_SIZE))
                     ? IW'(WEIGHT_TABLE_SIZE - 1) : IW'(qshort);

  // The divider serves the per-point table index and the final quotient.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.long_div = (state == S_RANGE);
    div_numer = DIV_NW'(abs_dx) * DIV_NW'(WEIGHT_TABLE_SIZE);
    div_denom = DIV_DW'(s18);
    if (state == S_RANGE) begin
      div_numer = DIV_NW'(nfin);
      div_denom = DIV_DW'(den);
      div_req.start = nfin < (FIN_W'(den) << 32);
    end else if (state == S_CHECK) begin
      div_req.start = (xi >= lo) && (xi <= hi) && (kernel_select == KSEL_NORMAL)
                    && (s18 != '0);
    end
  end

  krs_divider #(
    .NW(DIV_NW),
    .DW(DIV_DW),
    .SHORT_BITS(QW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .numer(div_numer),
    .denom(div_denom),
    .rsp(div_rsp),
    .quot(div_quot)
  );

  krs_weight_rom #(
    .WEIGHT_TABLE_SIZE(WEIGHT_TABLE_SIZE)
  ) u_rom (
    .clk(clk),
    .addr(rom_addr),
    .weight(rom_w)
  );

  // Sample memory: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready && req_word.mode == MODE_LOAD
        && stored_count < CW'(MAX_SAMPLES)) begin
      abscissa_store[stored_count[AW-1:0]] <= req_word.point_x;
      ordinate_store[stored_count[AW-1:0]] <= req_word.sample_y;
    end
    rd_x <= abscissa_store[scan[AW-1:0]];
    rd_y <= ordinate_store[scan[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kernel_select <= KSEL_RESET;
      bandwidth     <= BANDWIDTH_RESET;
      stored_count  <= '0;
      window_start  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_KERNEL_SELECT) kernel_select <= cfg_data[1:0];
        else bandwidth <= cfg_data;
      end
      // In S_DONE the output register is refilled below instead.
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req_word.mode)
              MODE_CLEAR: begin
                stored_count <= '0;
                window_start <= '0;
              end
              MODE_LOAD: begin
                if (stored_count < CW'(MAX_SAMPLES)) stored_count <= stored_count + 1'b1;
              end
              MODE_QUERY: begin
                qx    <= req_word.point_x;
                state <= S_SCALE;
              end
              default: ;
            endcase
          end
        end
        S_SCALE: begin
          case (kernel_select)
            KSEL_BOX:    s18 <= {bandwidth, 1'b0};
            KSEL_NORMAL: s18 <= scale_prod[62:30];
            default:     s18 <= '0;
          endcase
          wbox  <= (kernel_select == KSEL_BOX) ? WEIGHT_ONE : '0;
          state <= S_BOUND;
        end
        S_BOUND: begin
          lo    <= 35'(qx) - $signed({2'b00, cutoff});
          hi    <= 35'(qx) + $signed({2'b00, cutoff});
          scan  <= CW'(window_start);
          num   <= '0;
          den   <= '0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= (scan >= stored_count) ? S_ROUND : S_CHECK;
        end
        S_CHECK: begin
          if (xi < lo) begin
            // A point below the window becomes the new window start.
            window_start <= scan[AW-1:0];
            scan  <= scan + 1'b1;
            state <= S_FETCH;
          end else if (xi > hi) begin
            state <= S_ROUND;
          end else if (kernel_select == KSEL_NORMAL) begin
            rom_addr <= '0;
            state <= (s18 != '0) ? S_IDX_WAIT : S_ROM;
          end else begin
            state <= S_MUL;
          end
        end
        S_IDX_WAIT: begin
          if (div_rsp.done) begin
            rom_addr <= idx_clamped;
            state    <= S_ROM;
          end
        end
        S_ROM: begin
          state <= S_MUL;
        end
        S_MUL: begin
          w     <= wsel;
          prod  <= $signed({1'b0, wsel}) * $signed(rd_y);
          state <= S_ACC;
        end
        S_ACC: begin
          num   <= num + NUM_W'(prod);
          den   <= den + DEN_W'(w);
          scan  <= scan + 1'b1;
          state <= S_FETCH;
        end
        S_ROUND: begin
          if (den == '0) begin
            res.estimate       <= '0;
            res.estimate_valid <= 1'b0;
            state <= S_DONE;
          end else begin
            neg   <= num[NUM_W-1];
            nfin  <= FIN_W'(mag) + FIN_W'(den >> 1);
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          res.estimate_valid <= 1'b1;
          if (div_req.start) begin
            state <= S_Q_WAIT;
          end else begin
            // Quotient of 2^32 or more: saturate without dividing.
            res.estimate <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            state <= S_DONE;
          end
        end
        S_Q_WAIT: begin
          if (div_rsp.done) begin
            if (neg) begin
              res.estimate <= (div_quot > 32'h8000_0000) ? 32'sh8000_0000
                                                         : $signed(-div_quot);
            end else begin
              res.estimate <= (div_quot > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                         : $signed(div_quot);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_word  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/krs_checker.sv -----
// Port-level checker for the kernel regression smoother, bound to the top.
// Depends on krs_pkg and the assertion macros header.
`default_nettype none
`include "kernel_regression_smoother_unit_defines.svh"
module krs_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire krs_pkg::req_word_t req_word,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire krs_pkg::rsp_word_t rsp_word
);
  import krs_pkg::*;

  // A reset leaves no response word pending.
  `KRS_CHECK_ALWAYS(a_reset_clears, rst, !rsp_valid)
  // A stalled response word holds its value.
  `KRS_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
  // A missing value always reads as zero.
  `KRS_CHECK_NOW(a_invalid_zero, rsp_valid && !rsp_word.estimate_valid,
                 rsp_word.estimate == 32'sd0)
  // An accepted query keeps the block busy for the next cycle.
  `KRS_CHECK_NEXT(a_query_busy, req_valid && req_ready && req_word.mode == MODE_QUERY,
                  !req_ready)

endmodule

bind kernel_regression_smoother_unit krs_checker u_krs_checker (.*);
`default_nettype wire

// ----- bench/tb_kernel_regression_smoother_unit.sv -----
// Self-checking testbench for kernel_regression_smoother_unit.
// Depends on krs_pkg and the block's RTL. A behavioral smoother predicts
// every query response, which the monitor checks in order.
`default_nettype none
module tb_kernel_regression_smoother_unit;
  import krs_pkg::*;

  localparam int MAX_PTS = 1024;
  localparam int WT_SIZE = 256;
  localparam longint unsigned BOX_C = 64'd2147483648;
  localparam longint unsigned NORM_C = 64'd1591932205;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_word_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp_word;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  kernel_regression_smoother_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Behavioral copy of the smoother state and its registers.
  longint sample_x [MAX_PTS];
  longint sample_y [MAX_PTS];
  int unsigned n_stored;
  int unsigned scan_base;
  logic [1:0] kernel_sel;
  logic [30:0] bw_reg;
  longint unsigned gauss_tab [WT_SIZE];

  req_word_t pending_words[$];
  rsp_word_t estimates_due[$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;

  // exp(-t) with t in Q32, result in Q0.32, by a Taylor series on the
  // fraction times a table of exp(-k) for the whole part.
  function automatic longint unsigned exp_neg(input longint unsigned t);
    longint unsigned whole_exp [8];
    longint unsigned k;
    longint unsigned f;
    longint unsigned term;
    longint acc;
    whole_exp = '{64'd4294967295, 64'd1580030169, 64'd581260615, 64'd213833831,
                  64'd78665071, 64'd28939262, 64'd10646158, 64'd3916503};
    k = t >> 32;
    f = t & 64'hFFFF_FFFF;
    term = 64'h1_0000_0000;
    acc = 64'sh1_0000_0000;
    if (k > 7) return 0;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * f) >> 32) / longint'(n);
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'shFFFF_FFFF) acc = 64'shFFFF_FFFF;
    return (whole_exp[k] * longint'(acc)) >> 32;
  endfunction

  // Model one accepted request word; queries queue one expected estimate.
  function automatic void smooth_word(input req_word_t w);
    longint unsigned s18;
    longint cut, lo, hi, xi, num, px;
    longint unsigned den, wt, d, idx, mag, q;
    rsp_word_t r;
    bit neg;
    px = longint'(w.point_x);
    s18 = 0;
    cut = 0;
    num = 0;
    den = 0;
    case (w.mode)
      MODE_CLEAR: begin
        n_stored = 0;
        scan_base = 0;
      end
      MODE_LOAD: begin
        if (n_stored < MAX_PTS) begin
          sample_x[n_stored] = px;
          sample_y[n_stored] = longint'(w.sample_y);
          n_stored++;
        end
      end
      MODE_QUERY: begin
        if (kernel_sel == KSEL_BOX) begin
          s18 = (longint'(bw_reg) * BOX_C) >> 30;
          cut = longint'(s18 >> 2);
        end else if (kernel_sel == KSEL_NORMAL) begin
          s18 = (longint'(bw_reg) * NORM_C) >> 30;
          cut = longint'(s18);
        end
        lo = px - cut;
        hi = px + cut;
        for (int unsigned i = scan_base; i < n_stored; i++) begin
          xi = sample_x[i];
          if (xi < lo) begin
            scan_base = i;
          end else begin
            if (xi > hi) break;
            wt = 0;
            if (kernel_sel == KSEL_BOX) begin
              wt = 65536;
            end else if (kernel_sel == KSEL_NORMAL) begin
              d = (xi >= px) ? xi - px : px - xi;
              idx = (s18 != 0) ? (d * WT_SIZE) / s18 : 0;
              if (idx > WT_SIZE - 1) idx = WT_SIZE - 1;
              wt = gauss_tab[idx];
            end
            num += longint'(wt) * sample_y[i];
            den += wt;
          end
        end
        if (den == 0) begin
          r.estimate = '0;
          r.estimate_valid = 1'b0;
        end else begin
          neg = num < 0;
          mag = neg ? -num : num;
          q = (mag + den / 2) / den;
          if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            r.estimate = 32'(-q);
          end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            r.estimate = 32'(q);
          end
          r.estimate_valid = 1'b1;
        end
        estimates_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Driver: presents queued words, idling at random unless calm.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) smooth_word(req_word);
      if (!req_valid || req_ready) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          req_word <= pending_words.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every response word against the oldest estimate due.
  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (!rst) begin
      rsp_ready <= calm || ($urandom_range(99) >= 34);
      if (rsp_valid && rsp_ready) begin
        if (estimates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: estimate %0d valid %0d",
                     rsp_word.estimate, rsp_word.estimate_valid);
        end else begin
          exp_w = estimates_due.pop_front();
          if (rsp_word.estimate !== exp_w.estimate ||
              rsp_word.estimate_valid !== exp_w.estimate_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("estimate mismatch: expected %0d/%0d, got %0d/%0d",
                       exp_w.estimate, exp_w.estimate_valid,
                       rsp_word.estimate, rsp_word.estimate_valid);
          end
        end
      end
    end
  end

  function automatic req_word_t mk(input logic [1:0] m, input longint x, input longint y);
    req_word_t w;
    w.mode = m;
    w.point_x = 32'(x);
    w.sample_y = 32'(y);
    return w;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Registers change only with the block idle; the model follows at once.
  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_KERNEL_SELECT) kernel_sel = val[1:0];
    else bw_reg = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold the sender off until every expected estimate has come back, then
  // leave room for a trailing load or clear to finish.
  task automatic drain();
    wait (pending_words.size() == 0 && !req_valid && estimates_due.size() == 0);
    repeat (64) @(posedge clk);
  endtask

  // Mostly well-formed batches: a sorted run of loads, then queries around it.
  task automatic random_words(input int n_words);
    int made;
    int npts, nq;
    longint x, span, base, top;
    made = 0;
    while (made < n_words) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(1) == 1) begin
          pending_words.push_back(mk(MODE_CLEAR, $urandom, $urandom));
          made++;
        end
        case ($urandom_range(3))
          0: span = longint'(bw_reg) / 4 + 1;
          1: span = longint'(bw_reg) + 1;
          2: span = longint'(bw_reg) * 3 + 1;
          default: span = $urandom_range(65536 * 8);
        endcase
        if (span > 64'sd33554432) span = 64'sd33554432;
        npts = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        base = longint'($signed(32'($urandom))) / (1 << $urandom_range(0, 12));
        x = base;
        for (int i = 0; i < npts; i++) begin
          x = clip32(x + $urandom_range(0, 32'(span)));
          pending_words.push_back(mk(MODE_LOAD, x, longint'($signed(32'($urandom)))));
          made++;
        end
        top = x;
        nq = $urandom_range(1, 6);
        for (int i = 0; i < nq; i++) begin
          x = clip32(base - span + longint'($urandom_range(0, 32'(top - base + 2 * span))));
          pending_words.push_back(mk(MODE_QUERY, x, $urandom));
          made++;
        end
      end else begin
        pending_words.push_back(mk(2'($urandom_range(3)), longint'($signed(32'($urandom))),
                                   longint'($signed(32'($urandom)))));
        made++;
      end
    end
  endtask

  initial begin
    longint unsigned tq;
    logic [30:0] bw_set [8];
    logic [1:0] ks_set [8];
    for (int i = 0; i < WT_SIZE; i++) begin
      tq = ((64'd8 * i * i) << 32) / (WT_SIZE * WT_SIZE);
      gauss_tab[i] = (exp_neg(tq) + 32768) >> 16;
    end
    gauss_tab[0] = 65536;
    n_stored = 0;
    scan_base = 0;
    kernel_sel = KSEL_RESET;
    bw_reg = BANDWIDTH_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extremes of every field, the unused mode,
    // a load that does not sort, and queries at both ends of the range.
    pending_words.push_back(mk(MODE_QUERY, 0, 0));
    pending_words.push_back(mk(MODE_LOAD, -64'sd2147483648, -64'sd2147483648));
    pending_words.push_back(mk(MODE_LOAD, -64'sd2147483648, 64'sd2147483647));
    pending_words.push_back(mk(MODE_QUERY, -64'sd2147483648, 0));
    pending_words.push_back(mk(2'd3, 0, 0));
    pending_words.push_back(mk(MODE_LOAD, 0, 65536));
    pending_words.push_back(mk(MODE_LOAD, 32768, -65536));
    pending_words.push_back(mk(MODE_LOAD, -65536, 12345));
    pending_words.push_back(mk(MODE_LOAD, 64'sd2147483647, 64'sd2147483647));
    pending_words.push_back(mk(MODE_QUERY, 0, 0));
    pending_words.push_back(mk(MODE_QUERY, 64'sd2147483647, 0));
    pending_words.push_back(mk(MODE_QUERY, 0, 0));
    pending_words.push_back(mk(MODE_CLEAR, -1, -1));
    pending_words.push_back(mk(MODE_QUERY, 0, 0));
    drain();

    // Every kernel code and the bandwidth extremes, in several orders.
    ks_set = '{KSEL_NORMAL, 2'd0, 2'd3, KSEL_BOX, KSEL_NORMAL, KSEL_BOX,
               KSEL_NORMAL, KSEL_BOX};
    bw_set = '{31'd65536, 31'd65536, 31'd131072, 31'd1, 31'd1, 31'h7FFF_FFFF,
               31'h7FFF_FFFF, 31'($urandom_range(1, 1 << 22))};
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_KERNEL_SELECT, 31'(ks_set[p]));
      write_reg(REG_BANDWIDTH, bw_set[p]);
      calm = (p == 4);
      random_words((p == 2 || p == 3) ? 40 : 80);
      drain();
    end
    calm = 1'b0;

    // Fill past capacity; the extra loads are dropped and a wide query
    // walks the whole store.
    write_reg(REG_KERNEL_SELECT, 31'(KSEL_BOX));
    write_reg(REG_BANDWIDTH, 31'h7FFF_FFFF);
    pending_words.push_back(mk(MODE_CLEAR, 0, 0));
    for (int i = 0; i < MAX_PTS + 3; i++)
      pending_words.push_back(mk(MODE_LOAD, i * 256, longint'($signed(32'($urandom)))));
    pending_words.push_back(mk(MODE_QUERY, 0, 0));
    pending_words.push_back(mk(MODE_QUERY, 64'sd131072, 0));
    drain();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && estimates_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/krs_pkg.sv
design/krs_weight_rom.sv
design/krs_divider.sv
design/kernel_regression_smoother_unit.sv
design/krs_checker.sv
bench/tb_kernel_regression_smoother_unit.sv
